>>> rtl/rrjs_pkg.sv
`timescale 1ns / 1ps
package rrjs_pkg;

	localparam int unsigned JobSlotsDefault = 8;
	localparam int unsigned QueueDepth      = 2;
	localparam logic [7:0]  QuantumReset    = 8'd1;

	typedef enum logic {
		OP_ADD  = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_ACCEPTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_SERVED   = 2'd2,
		ST_NONE     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_SCAN = 2'd1,
		BK_EXEC = 2'd2,
		BK_OUT  = 2'd3
	} bk_state_t;

	// A classified item as it travels from the front to the back.
	typedef struct packed {
		op_t         op;
		logic [7:0]  job_id;
		logic [31:0] arrival_time;
		logic [15:0] duration;
	} job_cmd_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  served_id;
		logic [15:0] remaining;
		logic [31:0] slice_start;
		logic [7:0]  executed;
	} job_res_t;

endpackage

>>> rtl/round_robin_job_scheduler.sv
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// input     in_valid / in_stall   op, job_id, arrival_time, duration
// output    out_valid / out_stall status, served_id, remaining, slice_start, executed
// config    quantum_we            quantum_wdata
//
// An add occupies the back end in the state in which it leaves the queue and the state
// in which its result is presented. A tick scans one slot per cycle, then executes a
// slice in BK_EXEC when a job is served and presents its result in BK_OUT.
// An input transfer reaches the queue head in the cycle after it, so with no stalls an
// add leaves the queue as it reaches the head, and its result is registered for output.
// The front queue holds two items and keeps taking transfers while the back works, as long as it has room.
// Reset clears slot valid bits, global time, quantum (to 1) and all control state.
// A result holds stable in its output register while out_stall is high.
module round_robin_job_scheduler #(
	parameter int unsigned JOB_SLOTS = rrjs_pkg::JobSlotsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [7:0]  job_id,
	input  logic [31:0] arrival_time,
	input  logic [15:0] duration,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [7:0]  served_id,
	output logic [15:0] remaining,
	output logic [31:0] slice_start,
	output logic [7:0]  executed,
	input  logic        quantum_we,
	input  logic [7:0]  quantum_wdata
);

	logic [7:0]         quantum_q;
	rrjs_pkg::job_cmd_t in_cmd;
	rrjs_pkg::job_cmd_t q_cmd;
	rrjs_pkg::job_res_t res;
	logic               q_valid;
	logic               q_take;

	// The quantum register; a zero quantum is treated as one in the back end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= rrjs_pkg::QuantumReset;
		end else if (quantum_we) begin
			quantum_q <= quantum_wdata;
		end
	end

	assign in_cmd.op           = rrjs_pkg::op_t'(op);
	assign in_cmd.job_id       = job_id;
	assign in_cmd.arrival_time = arrival_time;
	assign in_cmd.duration     = duration;

	rrjs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_cmd   (in_cmd),
		.q_valid  (q_valid),
		.q_take   (q_take),
		.q_cmd    (q_cmd)
	);

	rrjs_back #(
		.JOB_SLOTS (JOB_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.quantum   (quantum_q),
		.q_valid   (q_valid),
		.q_take    (q_take),
		.q_cmd     (q_cmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (res)
	);

	assign status      = res.status;
	assign served_id   = res.served_id;
	assign remaining   = res.remaining;
	assign slice_start = res.slice_start;
	assign executed    = res.executed;

`ifndef SYNTH
	// A served slice never runs longer than the quantum allows.
	a_exec_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == rrjs_pkg::ST_SERVED |->
			executed <= ((quantum_q == 8'd0) ? 8'd1 : quantum_q))
		else $error("slice ran past quantum");

	// Fields other than status are zero unless a job was served.
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != rrjs_pkg::ST_SERVED |->
			served_id == 8'd0 && remaining == 16'd0 && executed == 8'd0)
		else $error("stray result fields");

	// A result that was not taken is still presented in the next cycle.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("result dropped under stall");
`endif

endmodule

>>> rtl/rrjs_front.sv
`timescale 1ns / 1ps
// Input stage and short queue towards the back end.
module rrjs_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  rrjs_pkg::job_cmd_t in_cmd,
	output logic               q_valid,
	input  logic               q_take,
	output rrjs_pkg::job_cmd_t q_cmd
);

	localparam int unsigned Depth = rrjs_pkg::QueueDepth;
	localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

	rrjs_pkg::job_cmd_t mem_q [Depth];
	logic [AddrW-1:0]   wr_ptr_q;
	logic [AddrW-1:0]   rd_ptr_q;
	logic [AddrW:0]     count_q;
	logic               push;
	logic               pop;

	assign in_stall = (count_q == (AddrW+1)'(Depth));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != '0);
	assign pop      = q_valid && q_take;
	assign q_cmd    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (AddrW+1)'(push) - (AddrW+1)'(pop);
		end
	end

endmodule

>>> rtl/rrjs_back.sv
`timescale 1ns / 1ps
// Slot table, sequential scan and slice execution.
module rrjs_back #(
	parameter int unsigned JOB_SLOTS = rrjs_pkg::JobSlotsDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         quantum,
	input  logic               q_valid,
	output logic               q_take,
	input  rrjs_pkg::job_cmd_t q_cmd,
	output logic               out_valid,
	input  logic               out_stall,
	output rrjs_pkg::job_res_t out_res
);

	localparam int unsigned IdxW = $clog2(JOB_SLOTS);

	rrjs_pkg::bk_state_t state_q, state_d;

	logic [JOB_SLOTS-1:0] valid_q;
	logic [7:0]           job_q   [JOB_SLOTS];
	logic [31:0]          ready_q [JOB_SLOTS];
	logic [15:0]          left_q  [JOB_SLOTS];
	logic [31:0]          time_q;

	logic [IdxW:0]      scan_q;
	logic               found_q;
	logic [IdxW-1:0]    pick_q;
	logic [31:0]        best_q;
	rrjs_pkg::job_res_t res_q;

	logic [IdxW-1:0] scan_idx;
	logic            scan_last;
	logic            better;
	logic            free_any;
	logic [IdxW-1:0] free_idx;
	logic [31:0]     start;
	logic [7:0]      q_eff;
	logic [15:0]     run;
	logic [15:0]     rest;
	logic [32:0]     sum;

	assign scan_idx  = scan_q[IdxW-1:0];
	assign scan_last = (scan_q == (IdxW+1)'(JOB_SLOTS - 1));
	assign better    = valid_q[scan_idx] && (!found_q || ready_q[scan_idx] < best_q);

	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = JOB_SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = IdxW'(i);
			end
		end
	end

	assign start = (best_q > time_q) ? best_q : time_q;
	assign q_eff = (quantum == 8'd0) ? 8'd1 : quantum;
	assign run   = (left_q[pick_q] < {8'd0, q_eff}) ? left_q[pick_q] : {8'd0, q_eff};
	assign rest  = left_q[pick_q] - run;
	assign sum   = {1'b0, start} + {17'd0, run};

	assign out_valid = (state_q == rrjs_pkg::BK_OUT);
	assign out_res   = res_q;
	assign q_take    = (state_q == rrjs_pkg::BK_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rrjs_pkg::BK_IDLE: begin
				if (q_valid) begin
					state_d = (q_cmd.op == rrjs_pkg::OP_ADD) ? rrjs_pkg::BK_OUT
						: rrjs_pkg::BK_SCAN;
				end
			end
			rrjs_pkg::BK_SCAN: begin
				if (scan_last) begin
					state_d = (found_q || better) ? rrjs_pkg::BK_EXEC : rrjs_pkg::BK_OUT;
				end
			end
			rrjs_pkg::BK_EXEC: state_d = rrjs_pkg::BK_OUT;
			rrjs_pkg::BK_OUT: begin
				if (!out_stall) begin
					state_d = rrjs_pkg::BK_IDLE;
				end
			end
			default: state_d = rrjs_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrjs_pkg::BK_IDLE;
			valid_q <= '0;
			time_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == rrjs_pkg::BK_IDLE && q_valid && q_cmd.op == rrjs_pkg::OP_ADD
					&& free_any) begin
				valid_q[free_idx] <= 1'b1;
			end
			if (state_q == rrjs_pkg::BK_EXEC) begin
				if (rest == 16'd0) begin
					valid_q[pick_q] <= 1'b0;
				end
				time_q <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			rrjs_pkg::BK_IDLE: begin
				scan_q            <= '0;
				found_q           <= 1'b0;
				pick_q            <= '0;
				best_q            <= '0;
				res_q.served_id   <= '0;
				res_q.remaining   <= '0;
				res_q.slice_start <= '0;
				res_q.executed    <= '0;
				if (q_valid && q_cmd.op == rrjs_pkg::OP_ADD && !free_any) begin
					res_q.status <= rrjs_pkg::ST_FULL;
				end else begin
					res_q.status <= rrjs_pkg::ST_ACCEPTED;
				end
				if (q_valid && q_cmd.op == rrjs_pkg::OP_ADD && free_any) begin
					job_q[free_idx]   <= q_cmd.job_id;
					ready_q[free_idx] <= q_cmd.arrival_time;
					left_q[free_idx]  <= q_cmd.duration;
				end
			end
			rrjs_pkg::BK_SCAN: begin
				scan_q <= scan_q + 1'b1;
				if (better) begin
					found_q <= 1'b1;
					pick_q  <= scan_idx;
					best_q  <= ready_q[scan_idx];
				end
				if (scan_last && !(found_q || better)) begin
					res_q.status <= rrjs_pkg::ST_NONE;
				end
			end
			rrjs_pkg::BK_EXEC: begin
				if (rest != 16'd0) begin
					left_q[pick_q]  <= rest;
					ready_q[pick_q] <= start;
				end
				res_q.status      <= rrjs_pkg::ST_SERVED;
				res_q.served_id   <= job_q[pick_q];
				res_q.remaining   <= rest;
				res_q.slice_start <= start;
				res_q.executed    <= run[7:0];
			end
			rrjs_pkg::BK_OUT: begin
			end
			default: begin
			end
		endcase
	end

endmodule
